// ----- rtl/bwta_pkg.sv -----
// ----------------------------------------------------------------------------
// bwta_pkg: shared types and constants for the bounded wait tick accumulator
// Field widths, status codes, limits and the beat layouts of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package bwta_pkg;

   // Limits of one wait
   localparam longint unsigned MAX_WAIT_TICKS = 64'd4194304;
   localparam longint unsigned POLLS_PER_TICK = 64'd64;

   // Target holds 1..MAX_WAIT_TICKS, poll bound holds up to MAX * POLLS
   localparam int unsigned TARGET_W = $clog2(MAX_WAIT_TICKS + 64'd1);
   localparam int unsigned POLL_W   = $clog2(MAX_WAIT_TICKS * POLLS_PER_TICK + 64'd1);

   // Field widths
   localparam int unsigned WIDTH_W   = 6;
   localparam int unsigned TICKS_W   = 32;
   localparam int unsigned SAMPLE_W  = 32;
   localparam int unsigned ELAPSED_W = 60;

   // Beat widths (rounded up to whole bytes)
   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned RSP_TDATA_W = 64;

   // Accepted counter widths and their masks
   localparam logic [WIDTH_W-1:0]  WIDTH_NARROW = 6'd24;
   localparam logic [WIDTH_W-1:0]  WIDTH_WIDE   = 6'd32;
   localparam logic [SAMPLE_W-1:0] MASK_NARROW  = 32'h00FF_FFFF;
   localparam logic [SAMPLE_W-1:0] MASK_WIDE    = 32'hFFFF_FFFF;

   typedef enum logic {
      OP_BEGIN = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_BAD_WIDTH    = 2'd1,
      ST_BAD_INTERVAL = 2'd2,
      ST_STALLED      = 2'd3
   } status_type;

   // One input item
   typedef struct packed {
      op_type               op;
      logic [TICKS_W-1:0]   ticks;
      logic [SAMPLE_W-1:0]  sample;
   } item_type;

   // One result item
   typedef struct packed {
      status_type            status;
      logic                  done;
      logic [ELAPSED_W-1:0]  elapsed;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/bwta_in_reg.sv -----
// ----------------------------------------------------------------------------
// bwta_in_reg: input register of the tick accumulator
// Captures one request beat; frees itself whenever the item moves on, so a
// new beat can be taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bwta_in_reg (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [bwta_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [31:0] ticks, [63:32] sample
   input  wire  [0:0]                           req_tuser,   // [0] op
   input  wire                                  advance,
   output logic                                 item_valid,
   output bwta_pkg::item_type                   item
);
   import bwta_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // Slot is free if empty or the held item leaves this cycle
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.op     <= op_type'(req_tuser[0]);
         item_ff.ticks  <= req_tdata[TICKS_W-1:0];
         item_ff.sample <= req_tdata[TICKS_W +: SAMPLE_W];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- rtl/bwta_fold.sv -----
// ----------------------------------------------------------------------------
// bwta_fold: wait state and per-item arithmetic
// Holds target, poll limit, elapsed count and last sample; works out the
// result of the held item and commits the new state when it moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module bwta_fold (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  advance,
   input  wire  bwta_pkg::item_type             item,
   input  wire  [bwta_pkg::WIDTH_W-1:0]         counter_width,
   output bwta_pkg::result_type                 result
);
   import bwta_pkg::*;

   logic [TARGET_W-1:0]  target_ff,  target_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [POLL_W-1:0]    poll_ff,    poll_in;
   logic [POLL_W-1:0]    bound_ff,   bound_in;
   logic [SAMPLE_W-1:0]  last_ff,    last_in;
   logic                 wide_ff,    wide_in;

   logic                 width_ok, interval_ok, begin_wide;
   logic [SAMPLE_W-1:0]  begin_mask, step_mask, masked, delta;
   logic [ELAPSED_W:0]   sum;
   logic [ELAPSED_W-1:0] elapsed_sat;

   // Begin checks
   assign begin_wide  = (counter_width == WIDTH_WIDE);
   assign width_ok    = (counter_width == WIDTH_NARROW) || begin_wide;
   assign interval_ok = (item.ticks != '0) &&
                        (item.ticks <= TICKS_W'(MAX_WAIT_TICKS));
   assign begin_mask  = begin_wide ? MASK_WIDE : MASK_NARROW;

   // Step: wrap-folded delta, saturating add
   assign step_mask   = wide_ff ? MASK_WIDE : MASK_NARROW;
   assign masked      = item.sample & step_mask;
   assign delta       = (masked - last_ff) & step_mask;
   assign sum         = {1'b0, elapsed_ff} + (ELAPSED_W + 1)'(delta);
   assign elapsed_sat = sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : sum[ELAPSED_W-1:0];

   always_comb begin
      target_in      = target_ff;
      elapsed_in     = elapsed_ff;
      poll_in        = poll_ff;
      bound_in       = bound_ff;
      last_in        = last_ff;
      wide_in        = wide_ff;
      result.status  = ST_OK;
      result.done    = 1'b0;
      result.elapsed = '0;
      case (item.op)
         OP_BEGIN: begin
            if (!width_ok) begin
               result.status = ST_BAD_WIDTH;
            end else if (!interval_ok) begin
               result.status = ST_BAD_INTERVAL;
            end else begin
               target_in  = item.ticks[TARGET_W-1:0];
               elapsed_in = '0;
               poll_in    = '0;
               bound_in   = POLL_W'(item.ticks[TARGET_W-1:0]) * POLL_W'(POLLS_PER_TICK);
               wide_in    = begin_wide;
               last_in    = item.sample & begin_mask;
            end
         end
         OP_STEP: begin
            if (poll_ff >= bound_ff) begin
               result.status  = ST_STALLED;
               result.elapsed = elapsed_ff;
            end else begin
               poll_in        = poll_ff + POLL_W'(1);
               elapsed_in     = elapsed_sat;
               last_in        = masked;
               result.done    = (elapsed_sat >= ELAPSED_W'(target_ff));
               result.elapsed = elapsed_sat;
            end
         end
         default: begin
            result.status = ST_OK;
         end
      endcase
   end

   // Commit state as the item leaves for the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         elapsed_ff <= '0;
         poll_ff    <= '0;
         bound_ff   <= '0;
         last_ff    <= '0;
         wide_ff    <= 1'b0;
      end else if (advance) begin
         target_ff  <= target_in;
         elapsed_ff <= elapsed_in;
         poll_ff    <= poll_in;
         bound_ff   <= bound_in;
         last_ff    <= last_in;
         wide_ff    <= wide_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bounded_wait_tick_accumulator.sv -----
// ----------------------------------------------------------------------------
// bounded_wait_tick_accumulator: bounded wait on a wrapping timer
// Follows one wait on a free-running 24- or 32-bit counter.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries items: tuser[0] is op (begin or step), tdata holds the
//   requested ticks and a raw counter sample. rsp_* returns one beat per
//   item with status, done flag and elapsed ticks, in item order.
//   csr_we/csr_wdata write the counter width; it is sampled at begin only,
//   so write it while no item is in flight.
// Pipeline and throughput:
//   A request beat passes the input register, then the result register.
//   One item per cycle is sustained while rsp_tready is high; the per-item
//   work is one 61-bit saturating add and compare in the fold stage.
// Reset:
//   Synchronous, active high. Both registers empty, width 24, poll limit
//   zero, so any step before an accepted begin reports stalled.
// Backpressure:
//   While rsp_tready is low the result register holds; the input register
//   takes one more beat, then req_tready drops until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_wait_tick_accumulator (
   input  wire                                  clock,
   input  wire                                  reset,
   // Request channel
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [bwta_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [31:0] ticks, [63:32] sample
   input  wire  [0:0]                           req_tuser,   // [0] op
   // Response channel
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [bwta_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [1:0] status, [2] done_res,
                                                              // [62:3] elapsed_ticks, [63] zero
   // Configuration
   input  wire                                  csr_we,
   input  wire  [bwta_pkg::WIDTH_W-1:0]         csr_wdata
);
   import bwta_pkg::*;

   logic                 item_valid, advance;
   item_type             item;
   result_type           result;
   logic [WIDTH_W-1:0]   width_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;

   // Counter width register
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_NARROW;
      end else if (csr_we) begin
         width_ff <= csr_wdata;
      end
   end

   // Held item moves on when the result register is free or draining
   assign advance = item_valid && (!out_valid_ff || rsp_tready);

   bwta_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   bwta_fold u_fold (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (item),
      .counter_width (width_ff),
      .result        (result)
   );

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.elapsed, out_ff.done, out_ff.status};

   // A held item never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !advance)
      else $error("result register overwritten while stalled");

   // Done is only raised on a successful step
   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.done) |-> (out_ff.status == ST_OK))
      else $error("done flagged with non-ok status");

   // Rejected begins carry no elapsed count
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_ff.status == ST_BAD_WIDTH ||
                      out_ff.status == ST_BAD_INTERVAL))
      |-> (out_ff.elapsed == '0 && !out_ff.done))
      else $error("rejected begin reported elapsed ticks");

   // An accepted request beat that advances from the input register yields a result beat
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (!out_valid_ff || rsp_tready)) |=>
      (item_valid && advance) |=> rsp_tvalid)
      else $error("accepted beat did not reach the result register");

endmodule

`default_nettype wire
